// File: rtl/ring_mult_small_mod_q_assert.svh
// Assertion macros for the ring multiplier RTL.
// Included by modules that check their own control logic; no other dependencies.
`ifndef RING_MULT_SMALL_MOD_Q_ASSERT_SVH
`define RING_MULT_SMALL_MOD_Q_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define RMSQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rmsq assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define RMSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rmsq assertion failed");

`else

`define RMSQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RMSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/rmsq_pkg.sv
// Shared constants and types for the ring multiplier in Z_q[x]/(x^p - x - 1).
// No dependencies; imported by every other file of the block but the assertion header.
package rmsq_pkg;

    // Ring parameters
    localparam int DEGREE_P  = 761;
    localparam int MODULUS_Q = 4591;

    // Field widths
    localparam int W_OP    = 2;
    localparam int W_IDX   = 10;
    localparam int W_COEFF = 13;
    localparam int W_SMALL = 2;

    // Cell position counter width
    localparam int W_PIDX = (DEGREE_P > 1) ? $clog2(DEGREE_P) : 1;

    // Opcodes
    localparam logic [W_OP-1:0] OP_LOAD  = 2'd0;
    localparam logic [W_OP-1:0] OP_CLEAR = 2'd1;
    localparam logic [W_OP-1:0] OP_STEP  = 2'd2;
    localparam logic [W_OP-1:0] OP_READ  = 2'd3;

    // One past the highest valid coefficient index
    localparam logic [W_IDX:0] IDX_LIMIT = (W_IDX+1)'(DEGREE_P);

    // Centered residue bound
    localparam int HALF_Q = (MODULUS_Q - 1) / 2;

    // Cell sum: prev + fold + g*f stays within four times the residue bound
    localparam int W_SUM = W_COEFF + 2;
    localparam int W_RED = W_SUM + 1;
    localparam logic signed [W_RED-1:0] RED_Q   = W_RED'(MODULUS_Q);
    localparam logic signed [W_RED-1:0] RED_2Q  = W_RED'(2 * MODULUS_Q);
    localparam logic signed [W_RED-1:0] RED_HI1 = W_RED'(HALF_Q);
    localparam logic signed [W_RED-1:0] RED_HI2 = W_RED'(HALF_Q + MODULUS_Q);

    // Load reduction: shift the signed input up by a multiple of q, then
    // take the quotient by reciprocal multiply and fix with one subtract
    localparam int W_U    = W_COEFF + 1;
    localparam int W_PROD = 2 * W_U;
    localparam int IN_SPAN = 2 ** (W_COEFF - 1);
    localparam int K_OFF  = ((IN_SPAN + MODULUS_Q - 1) / MODULUS_Q) * MODULUS_Q;
    localparam int RECIP  = (2 ** W_U) / MODULUS_Q;
    localparam logic [W_U-1:0] RECIP_U = W_U'(RECIP);
    localparam logic [W_U-1:0] Q_U     = W_U'(MODULUS_Q);
    localparam logic [W_U-1:0] HALF_U  = W_U'(HALF_Q);

    // Command from the sequencer to the row of cells
    typedef struct packed {
        logic                      clear;
        logic                      step;
        logic                      rotate;
        logic                      load;
        logic [W_IDX-1:0]          ld_idx;
        logic signed [W_COEFF-1:0] ld_val;
        logic signed [W_SMALL-1:0] g;
    } t_cell_ctl;

endpackage

// File: rtl/rmsq_in_if.sv
// Input channel of the ring multiplier: valid/ready plus one command item.
// Depends on rmsq_pkg for field widths.
interface rmsq_in_if import rmsq_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic [W_OP-1:0]           opcode;
    logic [W_IDX-1:0]          coeff_index;
    logic signed [W_COEFF-1:0] big_coeff;
    logic signed [W_SMALL-1:0] small_coeff;

    modport source (
        output valid, opcode, coeff_index, big_coeff, small_coeff,
        input  ready
    );

    modport sink (
        input  valid, opcode, coeff_index, big_coeff, small_coeff,
        output ready
    );

endinterface

// File: rtl/rmsq_out_if.sv
// Output channel of the ring multiplier: valid/ready plus one result item.
// Depends on rmsq_pkg for field widths.
interface rmsq_out_if import rmsq_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic [W_IDX-1:0]          out_index;
    logic signed [W_COEFF-1:0] out_coeff;

    modport source (
        output valid, out_index, out_coeff,
        input  ready
    );

    modport sink (
        input  valid, out_index, out_coeff,
        output ready
    );

endinterface

// File: rtl/ring_mult_small_mod_q.sv
// Top level of the ring multiplier: sequencer plus a row of DEGREE_P cells.
// Depends on rmsq_pkg, rmsq_in_if, rmsq_out_if, rmsq_cell and rmsq_ctrl.
//
//   Port     Dir  Payload                                      Handshake
//   i_in     in   opcode, coeff_index, big_coeff, small_coeff  valid/ready
//   o_out    out  out_index, out_coeff                         valid/ready
//
// Clear and Horner step are applied from a pending register; steps stream back to back.
// Load steps through reciprocal multiply, remainder, then centering and write.
// Read rotates the accumulator row a full turn past the last cell, which is the
// only read tap, then the value is registered.
// Synchronous active-low reset zeroes the accumulator; f cells hold no reset.
// A waiting result does not block loads, clears or steps; a new read waits
// for the output slot only at its end.
module ring_mult_small_mod_q import rmsq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rmsq_in_if.sink    i_in,
    rmsq_out_if.source o_out
);

    t_cell_ctl                 cell_ctl;
    logic signed [W_COEFF-1:0] acc [DEGREE_P];

    rmsq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_tap   (acc[DEGREE_P-1]),
        .o_ctl   (cell_ctl)
    );

    // Build the row: each cell takes its lower neighbor, cell 0 takes the top,
    // and cell 1 adds the top as the fold of x^p = x + 1
    for (genvar i = 0; i < DEGREE_P; i++) begin : g_cell
        logic                      ld_en;
        logic signed [W_COEFF-1:0] prev;
        logic signed [W_COEFF-1:0] fold;

        assign ld_en = cell_ctl.load && (cell_ctl.ld_idx == W_IDX'(i));

        if (i == 0) begin : g_first
            assign prev = acc[DEGREE_P-1];
        end else begin : g_rest
            assign prev = acc[i-1];
        end

        if (i == 1) begin : g_fold
            assign fold = acc[DEGREE_P-1];
        end else begin : g_nofold
            assign fold = '0;
        end

        rmsq_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (cell_ctl),
            .i_load_en (ld_en),
            .i_prev    (prev),
            .i_fold    (fold),
            .o_acc     (acc[i])
        );
    end

endmodule

// File: rtl/rmsq_cell.sv
// One cell of the multiplier row: holds one f coefficient and one accumulator
// coefficient. Depends on rmsq_pkg.
module rmsq_cell import rmsq_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cell_ctl                 i_ctl,
    input  logic                      i_load_en,
    input  logic signed [W_COEFF-1:0] i_prev,
    input  logic signed [W_COEFF-1:0] i_fold,
    output logic signed [W_COEFF-1:0] o_acc
);

    localparam logic [W_SMALL-1:0] G_POS_ONE = 2'b01;
    localparam logic [W_SMALL-1:0] G_NEG_ONE = 2'b11;
    localparam logic [W_SMALL-1:0] G_NEG_TWO = 2'b10;

    logic signed [W_COEFF-1:0] r_f;
    logic signed [W_COEFF-1:0] r_acc;
    logic signed [W_COEFF-1:0] n_acc;
    logic signed [W_SUM-1:0]   gf;
    logic signed [W_SUM-1:0]   sum;
    logic signed [W_RED-1:0]   s_ext;
    logic signed [W_RED-1:0]   red;

    // Form g*f for a ternary g (and the -2 pattern) without a multiplier
    always_comb begin
        case (i_ctl.g)
            G_POS_ONE: gf = W_SUM'(r_f);
            G_NEG_ONE: gf = -W_SUM'(r_f);
            G_NEG_TWO: gf = -(W_SUM'(r_f) <<< 1);
            default:   gf = '0;
        endcase
    end

    // Shifted neighbor, fold term and product, then center mod q
    assign sum   = W_SUM'(i_prev) + W_SUM'(i_fold) + gf;
    assign s_ext = W_RED'(sum);

    always_comb begin
        if (s_ext > RED_HI2) begin
            red = s_ext - RED_2Q;
        end else if (s_ext > RED_HI1) begin
            red = s_ext - RED_Q;
        end else if (s_ext < -RED_HI2) begin
            red = s_ext + RED_2Q;
        end else if (s_ext < -RED_HI1) begin
            red = s_ext + RED_Q;
        end else begin
            red = s_ext;
        end
    end

    // Select the next accumulator value
    always_comb begin
        if (i_ctl.clear) begin
            n_acc = '0;
        end else if (i_ctl.step) begin
            n_acc = red[W_COEFF-1:0];
        end else if (i_ctl.rotate) begin
            n_acc = i_prev;
        end else begin
            n_acc = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    // Capture the f coefficient addressed to this cell
    always_ff @(posedge i_clk) begin
        if (i_load_en) begin
            r_f <= i_ctl.ld_val;
        end
    end

    assign o_acc = r_acc;

endmodule

// File: rtl/rmsq_ctrl.sv
// Sequencer of the ring multiplier: item handshake, load reduction, readout
// by rotating the cell row, and the output register. Depends on rmsq_pkg.
`include "ring_mult_small_mod_q_assert.svh"

module rmsq_ctrl import rmsq_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    rmsq_in_if.sink                   i_in,
    rmsq_out_if.source                o_out,
    input  logic signed [W_COEFF-1:0] i_tap,
    output t_cell_ctl                 o_ctl
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LD_MUL = 3'd1;
    localparam logic [2:0] ST_LD_RED = 3'd2;
    localparam logic [2:0] ST_LD_WR  = 3'd3;
    localparam logic [2:0] ST_ROT    = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    logic [2:0]                r_state;
    logic [2:0]                n_state;
    logic                      r_pend_clear;
    logic                      n_pend_clear;
    logic                      r_pend_step;
    logic                      n_pend_step;
    logic signed [W_SMALL-1:0] r_g;
    logic signed [W_SMALL-1:0] n_g;
    logic [W_IDX-1:0]          r_ld_idx;
    logic [W_IDX-1:0]          n_ld_idx;
    logic [W_U-1:0]            r_u;
    logic [W_U-1:0]            n_u;
    logic [W_PROD-1:0]         r_prod;
    logic [W_PROD-1:0]         n_prod;
    logic [W_U-1:0]            r_rem;
    logic [W_U-1:0]            n_rem;
    logic [W_IDX-1:0]          r_rd_idx;
    logic [W_IDX-1:0]          n_rd_idx;
    logic [W_PIDX-1:0]         r_cnt;
    logic [W_PIDX-1:0]         n_cnt;
    logic signed [W_COEFF-1:0] r_rd_val;
    logic signed [W_COEFF-1:0] n_rd_val;
    logic                      r_out_valid;
    logic                      n_out_valid;
    logic [W_IDX-1:0]          r_out_idx;
    logic [W_IDX-1:0]          n_out_idx;
    logic signed [W_COEFF-1:0] r_out_coeff;
    logic signed [W_COEFF-1:0] n_out_coeff;

    logic                      in_fire;
    logic                      out_fire;
    logic                      out_free;
    logic signed [W_U:0]       u_sum;
    logic [W_U-1:0]            quot;
    logic [W_PROD-1:0]         quot_q;
    logic [W_U-1:0]            rem_fix;
    logic signed [W_U:0]       rem_cen;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = r_out_valid && o_out.ready;
    assign out_free = !r_out_valid || o_out.ready;

    // Shift the signed load value up into the unsigned range
    assign u_sum = (W_U+1)'(i_in.big_coeff) + (W_U+1)'(K_OFF);

    // Quotient estimate is exact or one low; remainder lands in 0..2q-1
    assign quot   = r_prod[W_PROD-1:W_U];
    assign quot_q = W_PROD'(quot) * W_PROD'(Q_U);

    // Final correction and centering of the remainder
    assign rem_fix = (r_rem >= Q_U) ? (r_rem - Q_U) : r_rem;
    assign rem_cen = (rem_fix > HALF_U) ? ($signed({1'b0, rem_fix}) - $signed({1'b0, Q_U}))
                                        : $signed({1'b0, rem_fix});

    // Sequence items and hold results
    always_comb begin
        n_state      = r_state;
        n_pend_clear = 1'b0;
        n_pend_step  = 1'b0;
        n_g          = r_g;
        n_ld_idx     = r_ld_idx;
        n_u          = r_u;
        n_prod       = r_prod;
        n_rem        = r_rem;
        n_rd_idx     = r_rd_idx;
        n_cnt        = r_cnt;
        n_rd_val     = r_rd_val;
        n_out_valid  = r_out_valid && !out_fire;
        n_out_idx    = r_out_idx;
        n_out_coeff  = r_out_coeff;

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    case (i_in.opcode)
                        OP_LOAD: begin
                            n_u      = u_sum[W_U-1:0];
                            n_ld_idx = i_in.coeff_index;
                            n_state  = ST_LD_MUL;
                        end
                        OP_CLEAR: begin
                            n_pend_clear = 1'b1;
                        end
                        OP_STEP: begin
                            n_pend_step = 1'b1;
                            n_g         = i_in.small_coeff;
                        end
                        OP_READ: begin
                            n_rd_idx = i_in.coeff_index;
                            if ({1'b0, i_in.coeff_index} < IDX_LIMIT) begin
                                n_cnt   = W_PIDX'(DEGREE_P - 1);
                                n_state = ST_ROT;
                            end else begin
                                n_rd_val = '0;
                                n_state  = ST_OUT;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LD_MUL: begin
                n_prod  = W_PROD'(r_u) * W_PROD'(RECIP_U);
                n_state = ST_LD_RED;
            end
            ST_LD_RED: begin
                n_rem   = r_u - quot_q[W_U-1:0];
                n_state = ST_LD_WR;
            end
            ST_LD_WR: begin
                n_state = ST_IDLE;
            end
            ST_ROT: begin
                // Grab the coefficient as it passes the last cell
                if (W_IDX'(r_cnt) == r_rd_idx) begin
                    n_rd_val = i_tap;
                end
                if (r_cnt == '0) begin
                    n_state = ST_OUT;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = r_rd_idx;
                    n_out_coeff = r_rd_val;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pend_clear <= 1'b0;
            r_pend_step  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend_clear <= n_pend_clear;
            r_pend_step  <= n_pend_step;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g         <= n_g;
        r_ld_idx    <= n_ld_idx;
        r_u         <= n_u;
        r_prod      <= n_prod;
        r_rem       <= n_rem;
        r_rd_idx    <= n_rd_idx;
        r_cnt       <= n_cnt;
        r_rd_val    <= n_rd_val;
        r_out_idx   <= n_out_idx;
        r_out_coeff <= n_out_coeff;
    end

    // Drive the handshake and the cell command
    assign i_in.ready      = (r_state == ST_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.out_index = r_out_idx;
    assign o_out.out_coeff = r_out_coeff;

    assign o_ctl.clear  = r_pend_clear;
    assign o_ctl.step   = r_pend_step;
    assign o_ctl.rotate = (r_state == ST_ROT);
    assign o_ctl.load   = (r_state == ST_LD_WR);
    assign o_ctl.ld_idx = r_ld_idx;
    assign o_ctl.ld_val = rem_cen[W_COEFF-1:0];
    assign o_ctl.g      = r_g;

    // Rotation never overlaps an accumulator update
    `RMSQ_ASSERT_IMPL(a_rot_alone, i_clk, i_rst_n, r_state == ST_ROT, !r_pend_step && !r_pend_clear)
    // Rotation ends after the last position
    `RMSQ_ASSERT_NEXT(a_rot_end, i_clk, i_rst_n, r_state == ST_ROT && r_cnt == '0, r_state == ST_OUT)
    // A held result moves into a free output slot
    `RMSQ_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, r_state == ST_OUT && out_free, r_out_valid && r_state == ST_IDLE)
    // Out-of-range read yields zero without rotating
    `RMSQ_ASSERT_NEXT(a_rd_oor, i_clk, i_rst_n, in_fire && i_in.opcode == OP_READ && {1'b0, i_in.coeff_index} >= IDX_LIMIT, r_state == ST_OUT && r_rd_val == '0)

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for ring_mult_small_mod_q: multiply in Z_q[x]/(x^p - x - 1).
// Depends on rmsq_pkg, rmsq_in_if, rmsq_out_if and the block's RTL.
module tb_top;
    import rmsq_pkg::*;

    typedef struct packed {
        logic [W_OP-1:0]           op;
        logic [W_IDX-1:0]          idx;
        logic signed [W_COEFF-1:0] f_coeff;
        logic signed [W_SMALL-1:0] g_coeff;
        bit                        drain;
    } t_ring_cmd;

    typedef struct packed {
        logic [W_IDX-1:0]          idx;
        logic signed [W_COEFF-1:0] coeff;
    } t_product_coeff;

    localparam int IDX_MAX   = (1 << W_IDX) - 1;
    localparam int N_ITEMS   = 950;
    localparam int N_WATCH   = 6_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rmsq_in_if  in_if ();
    rmsq_out_if out_if ();

    ring_mult_small_mod_q uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Ring model: f coefficients and the Horner accumulator
    int f_store   [DEGREE_P];
    int acc_cells [DEGREE_P];

    t_ring_cmd      pend_q [$];
    t_product_coeff product_exp_q [$];
    t_ring_cmd      cur_cmd;
    int             n_queued = 0;
    int             n_exp = 0;
    int             n_got = 0;
    int             n_err = 0;
    int             gap_cnt = 0;
    int             stall_cnt = 0;
    bit             drv_calm = 1'b0;
    bit             mon_calm = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int center_q(int x);
        int r;
        r = x % MODULUS_Q;
        if (r < 0) r += MODULUS_Q;
        if (r > HALF_Q) r -= MODULUS_Q;
        return r;
    endfunction

    // Advance the ring model by one item; a read yields one expected coefficient
    function automatic void apply_ring_cmd(t_ring_cmd c);
        int             top;
        int             i;
        t_product_coeff r;
        case (c.op)
            OP_LOAD: begin
                if (int'(c.idx) < DEGREE_P)
                    f_store[c.idx] = center_q(int'($signed(c.f_coeff)));
            end
            OP_CLEAR: begin
                for (i = 0; i < DEGREE_P; i++) acc_cells[i] = 0;
            end
            OP_STEP: begin
                // multiply by x, fold x^p back as x + 1, then add g*f
                top = acc_cells[DEGREE_P-1];
                for (i = DEGREE_P - 1; i > 0; i--) acc_cells[i] = acc_cells[i-1];
                acc_cells[0] = top;
                acc_cells[1] += top;
                for (i = 0; i < DEGREE_P; i++)
                    acc_cells[i] = center_q(acc_cells[i] +
                                            int'($signed(c.g_coeff)) * f_store[i]);
            end
            OP_READ: begin
                r.idx   = c.idx;
                r.coeff = (int'(c.idx) < DEGREE_P) ? W_COEFF'(acc_cells[c.idx]) : '0;
                product_exp_q.push_back(r);
            end
        endcase
    endfunction

    // Mostly short gaps, a few long ones, none while calm
    function automatic int draw_gap(bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int rand_f_coeff();
        case ($urandom_range(0, 9))
            0:       return -(1 << (W_COEFF - 1));
            1:       return (1 << (W_COEFF - 1)) - 1;
            2:       return $urandom_range(0, 1) ? HALF_Q + $urandom_range(0, 1)
                                                 : -HALF_Q - $urandom_range(0, 1);
            3, 4:    return int'($signed(W_COEFF'($urandom)));
            default: return int'($urandom_range(0, 2 * HALF_Q)) - HALF_Q;
        endcase
    endfunction

    function automatic int rand_idx();
        if ($urandom_range(0, 9) == 0) return $urandom_range(DEGREE_P, IDX_MAX);
        return $urandom_range(0, DEGREE_P - 1);
    endfunction

    function automatic logic signed [W_SMALL-1:0] rand_ternary();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return W_SMALL'(-2);
        return W_SMALL'(r % 3 - 1);
    endfunction

    task automatic queue_cmd(logic [W_OP-1:0] op, int idx, int f_val, int g_val, bit drain);
        t_ring_cmd c;
        c.op      = op;
        c.idx     = W_IDX'(idx);
        c.f_coeff = W_COEFF'(f_val);
        c.g_coeff = W_SMALL'(g_val);
        c.drain   = drain;
        pend_q.push_back(c);
        n_queued++;
    endtask

    // Driver: present queued items, predict each accepted one
    always @(posedge i_clk) begin : drv_proc
        logic nxt_valid;
        int   nxt_gap;
        int   exp_after;
        nxt_valid = in_if.valid;
        nxt_gap   = gap_cnt;
        exp_after = n_exp;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
            nxt_gap   = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                apply_ring_cmd(cur_cmd);
                if (cur_cmd.op == OP_READ) exp_after = n_exp + 1;
                nxt_valid = 1'b0;
                if ($urandom_range(0, 49) == 0) drv_calm = !drv_calm;
                nxt_gap = draw_gap(drv_calm);
            end
            // hold off for the gap, or until all products are back on a drain item
            if (!nxt_valid) begin
                if (nxt_gap > 0) begin
                    nxt_gap--;
                end else if (pend_q.size() != 0 &&
                             (!pend_q[0].drain || exp_after == n_got)) begin
                    cur_cmd = pend_q.pop_front();
                    nxt_valid = 1'b1;
                    in_if.opcode      <= cur_cmd.op;
                    in_if.coeff_index <= cur_cmd.idx;
                    in_if.big_coeff   <= cur_cmd.f_coeff;
                    in_if.small_coeff <= cur_cmd.g_coeff;
                end
            end
        end
        in_if.valid <= nxt_valid;
        gap_cnt     <= nxt_gap;
        n_exp       <= exp_after;
    end

    // Monitor: check each product coefficient against the oldest expectation
    always @(posedge i_clk) begin : mon_proc
        int             nxt_stall;
        t_product_coeff want;
        nxt_stall = stall_cnt;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_cnt    <= 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (n_got < n_exp) begin
                    want = product_exp_q[n_got];
                    if (out_if.out_index !== want.idx) begin
                        $display("%0t: out_index expected %0d actual %0d",
                                 $time, want.idx, out_if.out_index);
                        n_err++;
                    end
                    if (out_if.out_coeff !== want.coeff) begin
                        $display("%0t: out_coeff[%0d] expected %0d actual %0d",
                                 $time, want.idx, want.coeff, out_if.out_coeff);
                        n_err++;
                    end
                    n_got <= n_got + 1;
                end else begin
                    $display("%0t: unexpected item expected none actual idx %0d coeff %0d",
                             $time, out_if.out_index, out_if.out_coeff);
                    n_err++;
                end
            end
            // pace the ready line
            if (nxt_stall == 0) begin
                if ($urandom_range(0, 99) == 0) mon_calm = !mon_calm;
                if ($urandom_range(0, 3) == 0) nxt_stall = draw_gap(mon_calm);
            end
            out_if.ready <= (nxt_stall == 0);
            if (nxt_stall > 0) nxt_stall--;
            stall_cnt <= nxt_stall;
        end
    end

    // Stimulus and end of run
    initial begin : stim_proc
        int order [DEGREE_P];
        int i;
        int j;
        int tmp;
        int len;
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.opcode      = OP_LOAD;
        in_if.coeff_index = '0;
        in_if.big_coeff   = '0;
        in_if.small_coeff = '0;
        out_if.ready      = 1'b0;

        // Reads of the cleared accumulator, in and out of range
        queue_cmd(OP_READ, 0, 0, 0, 1'b0);
        queue_cmd(OP_READ, DEGREE_P - 1, 0, 0, 1'b0);
        queue_cmd(OP_READ, DEGREE_P, 0, 0, 1'b0);
        queue_cmd(OP_READ, IDX_MAX, 0, 0, 1'b0);
        // Out-of-range loads are dropped; extreme values get reduced
        queue_cmd(OP_LOAD, IDX_MAX, 100, 0, 1'b0);
        queue_cmd(OP_LOAD, DEGREE_P, -5, 0, 1'b0);
        queue_cmd(OP_LOAD, 0, (1 << (W_COEFF - 1)) - 1, 0, 1'b0);
        queue_cmd(OP_LOAD, DEGREE_P - 1, -(1 << (W_COEFF - 1)), 0, 1'b0);
        queue_cmd(OP_LOAD, 1, HALF_Q, 0, 1'b0);
        queue_cmd(OP_LOAD, 2, -HALF_Q, 0, 1'b0);
        queue_cmd(OP_LOAD, 3, HALF_Q + 1, 0, 1'b0);
        queue_cmd(OP_LOAD, 4, -HALF_Q - 1, 0, 1'b0);
        queue_cmd(OP_CLEAR, 0, 0, 0, 1'b0);
        queue_cmd(OP_READ, 5, 0, 0, 1'b0);

        // Write every f entry, in shuffled order, before any step
        for (i = 0; i < DEGREE_P; i++) order[i] = i;
        for (i = DEGREE_P - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (i = 0; i < DEGREE_P; i++) queue_cmd(OP_LOAD, order[i], rand_f_coeff(), 0, 1'b0);

        // Steps with every g value, the first one after a full drain
        queue_cmd(OP_STEP, 0, 0, 1, 1'b1);
        queue_cmd(OP_STEP, 0, 0, -1, 1'b0);
        queue_cmd(OP_STEP, 0, 0, 0, 1'b0);
        queue_cmd(OP_STEP, 0, 0, -2, 1'b0);
        queue_cmd(OP_READ, 0, 0, 0, 1'b0);
        queue_cmd(OP_READ, 1, 0, 0, 1'b0);
        queue_cmd(OP_READ, DEGREE_P - 1, 0, 0, 1'b0);
        queue_cmd(OP_READ, DEGREE_P, 0, 0, 1'b0);

        // Random mix: short Horner runs, updates of f, reads and noise
        while (n_queued < N_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    if ($urandom_range(0, 1)) queue_cmd(OP_CLEAR, 0, 0, 0, 1'b0);
                    len = $urandom_range(1, 20);
                    for (i = 0; i < len; i++)
                        queue_cmd(OP_STEP, rand_idx(), rand_f_coeff(), rand_ternary(),
                                  i == 0 && $urandom_range(0, 9) == 0);
                    len = $urandom_range(1, 3);
                    for (i = 0; i < len; i++) queue_cmd(OP_READ, rand_idx(), 0, 0, 1'b0);
                end
                5, 6: begin
                    len = $urandom_range(1, 5);
                    for (i = 0; i < len; i++)
                        queue_cmd(OP_LOAD, rand_idx(), rand_f_coeff(), 0, 1'b0);
                end
                7, 8: begin
                    queue_cmd(OP_READ, rand_idx(), rand_f_coeff(), 0,
                              $urandom_range(0, 3) == 0);
                end
                default: begin
                    queue_cmd(W_OP'($urandom_range(0, 3)), $urandom_range(0, IDX_MAX),
                              int'($signed(W_COEFF'($urandom))),
                              int'($signed(W_SMALL'($urandom))), 1'b0);
                end
            endcase
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sample at the falling edge so the clocked blocks have settled
        while (pend_q.size() != 0 || in_if.valid || n_got != n_exp) @(negedge i_clk);
        repeat (DEGREE_P + 20) @(posedge i_clk);
        if (n_err == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(N_WATCH);
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
